// ===== rtl/etsc_pkg.sv =====
// etsc_pkg: shared types, codes and the prefix mapping function for the
// entity tag scheme converter. No dependencies.
package etsc_pkg;

  typedef enum logic [2:0] {
    PFX_O = 3'd0,
    PFX_B = 3'd1,
    PFX_I = 3'd2,
    PFX_L = 3'd3,
    PFX_U = 3'd4
  } prefix_t;

  localparam logic [1:0] SCHEME_BIO   = 2'd0;
  localparam logic [1:0] SCHEME_BILOU = 2'd1;
  localparam logic [1:0] SCHEME_IO    = 2'd2;

  // Result side of one processed item: up to two results, in order.
  typedef struct packed {
    logic [1:0] count;
    prefix_t    pfx0;
    logic       last0;
    prefix_t    pfx1;
    logic       last1;
  } emit_ctl_t;

  function automatic prefix_t emit_prefix(logic [1:0] scheme, logic in_span,
                                          logic starts, logic ends);
    prefix_t p;
    p = PFX_O;
    if (in_span) begin
      unique case (scheme)
        SCHEME_BIO: begin
          p = starts ? PFX_B : PFX_I;
        end
        SCHEME_BILOU: begin
          if (starts && ends) p = PFX_U;
          else if (starts)    p = PFX_B;
          else if (ends)      p = PFX_L;
          else                p = PFX_I;
        end
        default: begin
          p = PFX_I;  // IO, and the unused code
        end
      endcase
    end
    return p;
  endfunction

endpackage

// ===== rtl/etsc_core.sv =====
// etsc_core: span tracking and one-tag hold-back; turns one input tag into
// zero, one or two converted tags. Depends on etsc_pkg.
module etsc_core #(
  parameter int ENTITY_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             scheme,
  input  logic                   fire,
  input  logic [2:0]             pfx,
  input  logic [ENTITY_BITS-1:0] ent,
  input  logic                   sent_end,
  output etsc_pkg::emit_ctl_t    ctl,
  output logic [ENTITY_BITS-1:0] ent0,
  output logic [ENTITY_BITS-1:0] ent1
);

  logic                   held_valid, held_valid_next;
  logic                   held_in_span, held_in_span_next;
  logic                   held_starts_span, held_starts_span_next;
  logic [ENTITY_BITS-1:0] held_entity, held_entity_next;
  logic                   span_open, span_open_next;
  logic [ENTITY_BITS-1:0] span_entity, span_entity_next;

  logic                   known;
  logic                   new_in, new_starts, held_ends;
  logic [ENTITY_BITS-1:0] new_ent;
  etsc_pkg::prefix_t      held_pfx, new_pfx;
  logic [ENTITY_BITS-1:0] held_ent_out, new_ent_out;

  always_comb begin
    known      = 1'b1;
    new_in     = 1'b0;
    new_starts = 1'b0;
    new_ent    = '0;
    unique case (pfx)
      etsc_pkg::PFX_O: begin
      end
      etsc_pkg::PFX_B, etsc_pkg::PFX_U: begin
        new_in     = 1'b1;
        new_starts = 1'b1;
        new_ent    = ent;
      end
      etsc_pkg::PFX_I, etsc_pkg::PFX_L: begin
        new_in     = 1'b1;
        new_starts = !(span_open && span_entity == ent);
        new_ent    = ent;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // An unknown prefix can only close the sentence, so the held tag ends there.
  assign held_ends    = !known || !(new_in && !new_starts);
  assign held_pfx     = etsc_pkg::emit_prefix(scheme, held_in_span, held_starts_span,
                                              held_ends);
  assign new_pfx      = etsc_pkg::emit_prefix(scheme, new_in, new_starts, 1'b1);
  assign held_ent_out = held_in_span ? held_entity : '0;
  assign new_ent_out  = new_in ? new_ent : '0;

  always_comb begin
    ctl.count = 2'd0;
    ctl.pfx0  = held_pfx;
    ctl.last0 = 1'b0;
    ctl.pfx1  = new_pfx;
    ctl.last1 = 1'b1;
    ent0      = held_ent_out;
    ent1      = new_ent_out;
    if (!known) begin
      if (sent_end && held_valid) begin
        ctl.count = 2'd1;
        ctl.last0 = 1'b1;
      end
    end else if (held_valid) begin
      ctl.count = sent_end ? 2'd2 : 2'd1;
    end else if (sent_end) begin
      ctl.count = 2'd1;
      ctl.pfx0  = new_pfx;
      ctl.last0 = 1'b1;
      ent0      = new_ent_out;
    end
  end

  always_comb begin
    held_valid_next       = held_valid;
    held_in_span_next     = held_in_span;
    held_starts_span_next = held_starts_span;
    held_entity_next      = held_entity;
    span_open_next        = span_open;
    span_entity_next      = span_entity;
    if (fire) begin
      if (sent_end) begin
        held_valid_next       = 1'b0;
        held_in_span_next     = 1'b0;
        held_starts_span_next = 1'b0;
        held_entity_next      = '0;
        span_open_next        = 1'b0;
        span_entity_next      = '0;
      end else if (known) begin
        held_valid_next       = 1'b1;
        held_in_span_next     = new_in;
        held_starts_span_next = new_starts;
        held_entity_next      = new_ent;
        span_open_next        = new_in;
        span_entity_next      = new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid       <= 1'b0;
      held_in_span     <= 1'b0;
      held_starts_span <= 1'b0;
      held_entity      <= '0;
      span_open        <= 1'b0;
      span_entity      <= '0;
    end else begin
      held_valid       <= held_valid_next;
      held_in_span     <= held_in_span_next;
      held_starts_span <= held_starts_span_next;
      held_entity      <= held_entity_next;
      span_open        <= span_open_next;
      span_entity      <= span_entity_next;
    end
  end

endmodule

// ===== rtl/entity_tag_scheme_converter.sv =====
// entity_tag_scheme_converter: top level; input register, converter core and
// a four-entry result queue. Depends on etsc_pkg and etsc_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one entity tag per transfer:
//   prefix code, entity id and the sentence_end mark. Output channel
//   (out_valid / out_stall) carries converted tags, out_last on the final tag
//   of each sentence. Each tag is held back one transfer, so the first tag of
//   a sentence produces nothing and the last produces two results (one if it
//   is the only tag).
//   cfg_we / cfg_wdata write target_scheme (0 BIO, 1 BILOU, 2 IO); write it
//   only while the block is empty.
//   Path: a result released by an input transfer passes through the input
//   register, then the result queue, before out_valid rises.
//   Throughput: one input transfer per cycle while in_stall is low, one result
//   per cycle while out_stall is low; a transfer that releases two results
//   leaves an extra result, which the queue absorbs.
//   Stalls: the queue needs room for two results before the registered item
//   is processed; otherwise in_stall is raised and the item waits. A stalled
//   output holds its payload.
//   Reset: empties the queue and input register, clears the span state and
//   sets the scheme to BIO.
module entity_tag_scheme_converter #(
  parameter int ENTITY_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_prefix,
  input  logic [ENTITY_BITS-1:0] in_entity,
  input  logic                   sentence_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_prefix,
  output logic [ENTITY_BITS-1:0] out_entity,
  output logic                   out_last
);

  localparam int QDEPTH = 4;

  logic [1:0] target_scheme;

  logic                   inq_valid;
  logic [2:0]             inq_prefix;
  logic [ENTITY_BITS-1:0] inq_entity;
  logic                   inq_end;

  logic                   room, fire, pop;
  etsc_pkg::emit_ctl_t    ctl;
  logic [ENTITY_BITS-1:0] ent0, ent1;

  etsc_pkg::prefix_t      q_pfx  [QDEPTH];
  logic [ENTITY_BITS-1:0] q_ent  [QDEPTH];
  logic                   q_last [QDEPTH];
  logic [1:0]             wr_ptr, rd_ptr, wr_ptr_p1;
  logic [2:0]             count, count_next;

  assign room     = (count <= 3'(QDEPTH - 2));
  assign fire     = inq_valid && room;
  assign in_stall = inq_valid && !room;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_scheme <= etsc_pkg::SCHEME_BIO;
    end else if (cfg_we) begin
      target_scheme <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (!in_stall) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      inq_prefix <= in_prefix;
      inq_entity <= in_entity;
      inq_end    <= sentence_end;
    end
  end

  etsc_core #(
    .ENTITY_BITS (ENTITY_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .scheme   (target_scheme),
    .fire     (fire),
    .pfx      (inq_prefix),
    .ent      (inq_entity),
    .sent_end (inq_end),
    .ctl      (ctl),
    .ent0     (ent0),
    .ent1     (ent1)
  );

  // Result queue: up to two writes, one read per cycle while out_stall is low.
  assign wr_ptr_p1 = wr_ptr + 2'd1;

  always_ff @(posedge clk) begin
    if (fire && ctl.count != 2'd0) begin
      q_pfx[wr_ptr]  <= ctl.pfx0;
      q_ent[wr_ptr]  <= ent0;
      q_last[wr_ptr] <= ctl.last0;
    end
    if (fire && ctl.count == 2'd2) begin
      q_pfx[wr_ptr_p1]  <= ctl.pfx1;
      q_ent[wr_ptr_p1]  <= ent1;
      q_last[wr_ptr_p1] <= ctl.last1;
    end
  end

  always_comb begin
    count_next = count;
    if (fire) count_next = count_next + {1'b0, ctl.count};
    if (pop)  count_next = count_next - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (fire) wr_ptr <= wr_ptr + ctl.count;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count_next;
    end
  end

  assign out_valid  = (count != 3'd0);
  assign out_prefix = q_pfx[rd_ptr];
  assign out_entity = q_ent[rd_ptr];
  assign out_last   = q_last[rd_ptr];

endmodule
